/* rtl/ssmh_pkg.sv */
// shared constants and types for the set-of-sets modular exponentiation hash
`timescale 1ns / 1ps
package ssmh_pkg;

    localparam int unsigned NUM_WIDTH_DEF = 31;
    localparam int unsigned DATA_W        = 31;
    localparam int unsigned CMD_DEPTH     = 4;

    localparam logic [DATA_W-1:0] RESET_MODULUS  = 31'd60000607;
    localparam logic [15:0]       RESET_OFFSET   = 16'd4;
    localparam logic [15:0]       RESET_EXPONENT = 16'd20;

    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    localparam int unsigned PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_MODULUS  = 2'd0,
        REG_OFFSET   = 2'd1,
        REG_EXPONENT = 2'd2,
        REG_NONE     = 2'd3
    } ssmh_reg_idx_t;

    typedef struct packed {
        logic has_num;
        logic end_line;
        logic eos;
    } ssmh_flags_t;

endpackage

/* rtl/ssmh_front.sv */
// front end: digit accumulation and delimiter classification
`timescale 1ns / 1ps
module ssmh_front #(
    parameter int unsigned NUM_WIDTH = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [7:0]            text_byte,
    input  logic                  end_of_stream,
    input  logic                  q_full,
    output logic                  q_push,
    output ssmh_pkg::ssmh_flags_t q_flags,
    output logic [NUM_WIDTH-1:0]  q_num
);
    import ssmh_pkg::*;

    logic [NUM_WIDTH-1:0] number_acc_reg;
    logic [NUM_WIDTH-1:0] number_acc_next;
    logic                 accept;
    logic                 is_digit;
    logic                 is_newline;
    logic [NUM_WIDTH-1:0] digit_val;

    assign accept     = push && !q_full;
    assign is_digit   = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    assign is_newline = (text_byte == CHAR_NEWLINE);
    assign digit_val  = NUM_WIDTH'(text_byte - CHAR_ZERO);

    always_comb
    begin
        number_acc_next = number_acc_reg;
        q_push          = 1'b0;
        q_flags         = '0;
        q_num           = number_acc_reg;
        if (accept)
        begin
            if (!end_of_stream && is_digit)
            begin
                number_acc_next = (number_acc_reg << 3) + (number_acc_reg << 1) + digit_val;
            end
            else
            begin
                number_acc_next  = '0;
                q_flags.has_num  = (number_acc_reg != '0);
                q_flags.end_line = !end_of_stream && is_newline;
                q_flags.eos      = end_of_stream;
                q_push = q_flags.has_num || q_flags.end_line || q_flags.eos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_acc_reg <= '0;
        end
        else
        begin
            number_acc_reg <= number_acc_next;
        end
    end

endmodule

/* rtl/ssmh_fifo.sv */
// short command queue between front and back
`timescale 1ns / 1ps
module ssmh_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/ssmh_modmul.sv */
// bit-serial modular multiplier, one bit of a per cycle, msb first
`timescale 1ns / 1ps
module ssmh_modmul #(
    parameter int unsigned AW = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [AW-1:0]               a,
    input  logic [ssmh_pkg::DATA_W-1:0] b,
    input  logic [ssmh_pkg::DATA_W-1:0] m,
    output logic                        done,
    output logic [ssmh_pkg::DATA_W-1:0] result
);
    import ssmh_pkg::*;

    localparam int unsigned CW = $clog2(AW + 1);

    logic [AW-1:0]     a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [DATA_W-1:0] r_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W:0]   dbl;
    logic [DATA_W:0]   dbl_red;
    logic [DATA_W:0]   sum;
    logic [DATA_W:0]   sum_red;
    logic [DATA_W:0]   m_ext;

    assign m_ext   = {1'b0, m};
    assign dbl     = {r_reg, 1'b0};
    assign dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    assign sum     = dbl_red + (a_reg[AW-1] ? {1'b0, b_reg} : '0);
    assign sum_red = (sum >= m_ext) ? sum - m_ext : sum;
    assign done    = done_reg;
    assign result  = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            r_reg    <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                a_reg    <= a;
                b_reg    <= b;
                r_reg    <= '0;
                cnt_reg  <= CW'(AW);
            end
            else if (busy_reg)
            begin
                r_reg   <= sum_red[DATA_W-1:0];
                a_reg   <= a_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/ssmh_back.sv */
// back end: line and total sums, exponentiation sequencer and result register
`timescale 1ns / 1ps
module ssmh_back #(
    parameter int unsigned NUM_WIDTH = 31,
    parameter int unsigned AW        = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  ssmh_pkg::ssmh_flags_t       q_flags,
    input  logic [NUM_WIDTH-1:0]        q_num,
    output logic                        q_pop,
    input  logic [ssmh_pkg::DATA_W-1:0] mod_eff,
    input  logic [15:0]                 offset,
    input  logic [15:0]                 exponent,
    input  logic                        pop,
    output logic                        empty,
    output logic [ssmh_pkg::DATA_W-1:0] digest,
    output logic                        out_load
);
    import ssmh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CMD, S_LINECHK, S_LOOP, S_WAIT, S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_BASE, OP_MULR, OP_SQR, OP_ADD, OP_DIGEST
    } op_t;

    state_t            state_reg;
    op_t               op_reg;
    ssmh_flags_t       flags_reg;
    logic [NUM_WIDTH-1:0] num_reg;
    logic              hash_line_reg;
    logic [DATA_W-1:0] line_sum_reg;
    logic [DATA_W-1:0] total_sum_reg;
    logic [DATA_W-1:0] bb_reg;
    logic [DATA_W-1:0] r_reg;
    logic [15:0]       e_reg;
    logic [DATA_W-1:0] hold_reg;
    logic [DATA_W-1:0] digest_reg;
    logic              out_valid_reg;
    logic              mul_start_reg;
    logic [AW-1:0]     mul_a_reg;
    logic [DATA_W-1:0] mul_b_reg;
    logic              mul_done;
    logic [DATA_W-1:0] mul_res;
    logic [DATA_W-1:0] one;
    logic              pop_ok;

    assign one      = (mod_eff == DATA_W'(1)) ? '0 : DATA_W'(1);
    assign pop_ok   = pop && out_valid_reg;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || pop_ok);
    assign empty    = !out_valid_reg;
    assign digest   = digest_reg;

    ssmh_modmul #(.AW(AW)) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_reg),
        .a      (mul_a_reg),
        .b      (mul_b_reg),
        .m      (mod_eff),
        .done   (mul_done),
        .result (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_BASE;
            flags_reg     <= '0;
            num_reg       <= '0;
            hash_line_reg <= 1'b0;
            line_sum_reg  <= '0;
            total_sum_reg <= '0;
            bb_reg        <= '0;
            r_reg         <= '0;
            e_reg         <= '0;
            hold_reg      <= '0;
            digest_reg    <= '0;
            out_valid_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            if (pop_ok && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        flags_reg <= q_flags;
                        num_reg   <= q_num;
                        state_reg <= S_CMD;
                    end
                end
                S_CMD:
                begin
                    if (flags_reg.has_num)
                    begin
                        mul_a_reg     <= AW'(num_reg) + AW'(offset);
                        mul_b_reg     <= one;
                        op_reg        <= OP_BASE;
                        hash_line_reg <= 1'b0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_LINECHK;
                    end
                end
                S_LINECHK:
                begin
                    if (flags_reg.end_line || flags_reg.eos)
                    begin
                        if (line_sum_reg != '0)
                        begin
                            mul_a_reg     <= AW'(line_sum_reg) + AW'(offset);
                            mul_b_reg     <= one;
                            op_reg        <= OP_BASE;
                            hash_line_reg <= 1'b1;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_WAIT;
                        end
                        else if (flags_reg.eos)
                        begin
                            mul_a_reg     <= AW'(total_sum_reg);
                            mul_b_reg     <= one;
                            op_reg        <= OP_DIGEST;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_WAIT;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_LOOP:
                begin
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_WAIT;
                    if (e_reg == '0)
                    begin
                        mul_a_reg <= hash_line_reg ? AW'(total_sum_reg) + AW'(r_reg)
                                                   : AW'(line_sum_reg) + AW'(r_reg);
                        mul_b_reg <= one;
                        op_reg    <= OP_ADD;
                    end
                    else if (e_reg[0])
                    begin
                        mul_a_reg <= AW'(r_reg);
                        mul_b_reg <= bb_reg;
                        op_reg    <= OP_MULR;
                    end
                    else
                    begin
                        mul_a_reg <= AW'(bb_reg);
                        mul_b_reg <= bb_reg;
                        op_reg    <= OP_SQR;
                    end
                end
                S_WAIT:
                begin
                    if (mul_done)
                    begin
                        unique case (op_reg)
                            OP_BASE:
                            begin
                                bb_reg    <= mul_res;
                                r_reg     <= one;
                                e_reg     <= exponent;
                                state_reg <= S_LOOP;
                            end
                            OP_MULR:
                            begin
                                r_reg         <= mul_res;
                                mul_a_reg     <= AW'(bb_reg);
                                mul_b_reg     <= bb_reg;
                                op_reg        <= OP_SQR;
                                mul_start_reg <= 1'b1;
                            end
                            OP_SQR:
                            begin
                                bb_reg    <= mul_res;
                                e_reg     <= e_reg >> 1;
                                state_reg <= S_LOOP;
                            end
                            OP_ADD:
                            begin
                                if (hash_line_reg)
                                begin
                                    total_sum_reg <= mul_res;
                                    line_sum_reg  <= '0;
                                    if (flags_reg.eos)
                                    begin
                                        mul_a_reg     <= AW'(mul_res);
                                        mul_b_reg     <= one;
                                        op_reg        <= OP_DIGEST;
                                        mul_start_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        state_reg <= S_IDLE;
                                    end
                                end
                                else
                                begin
                                    line_sum_reg <= mul_res;
                                    state_reg    <= S_LINECHK;
                                end
                            end
                            OP_DIGEST:
                            begin
                                hold_reg  <= mul_res;
                                state_reg <= S_EMIT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || pop_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        digest_reg    <= hold_reg;
                        total_sum_reg <= '0;
                        line_sum_reg  <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/set_of_sets_modexp_hash.sv */
// top level of the set-of-sets modular exponentiation hash
// usage:
//   text enters one byte per transfer on push/full with end_of_stream as a flag;
//   an end_of_stream transfer produces one digest on the empty/pop side.
//   digits are folded into a number in the front end and never produce
//   work; a delimiter pushes a command into a four-entry queue only when it
//   ends a nonzero number, is a newline or comes with end_of_stream.
//   the back end runs each hash as square-and-multiply on one bit-serial
//   modular multiplier of 32 steps per product (NUM_WIDTH+1 above 31 bits),
//   and a number ended by a newline costs two hashes plus the sum reductions.
//   full rises only while the command queue holds four commands.
//   the digest waits in an output register; while pop stays low the back end
//   holds the next digest and then the queue fills, raising full.
//   reset clears all sums, the queue and the output register and loads the
//   register defaults modulus 60000607, offset 4, exponent 20.
//   configuration goes through the apb port at byte addresses 0, 4 and 8;
//   write it only while no work is pending; the block does not enforce that.
`timescale 1ns / 1ps
module set_of_sets_modexp_hash #(
    parameter int unsigned NUM_WIDTH = ssmh_pkg::NUM_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssmh_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   text_byte,
    input  logic                         end_of_stream,
    input  logic                         pop,
    output logic                         empty,
    output logic [ssmh_pkg::DATA_W-1:0]  digest
);
    import ssmh_pkg::*;

    localparam int unsigned AW = ((NUM_WIDTH > DATA_W) ? NUM_WIDTH : DATA_W) + 1;
    localparam int unsigned QW = $bits(ssmh_flags_t) + NUM_WIDTH;

    logic [DATA_W-1:0]    modulus_reg;
    logic [15:0]          offset_reg;
    logic [15:0]          exponent_reg;
    logic [DATA_W-1:0]    mod_eff;
    ssmh_reg_idx_t        reg_idx;
    logic                 cfg_wr;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    ssmh_flags_t          f_flags;
    ssmh_flags_t          b_flags;
    logic [NUM_WIDTH-1:0] f_num;
    logic [NUM_WIDTH-1:0] b_num;
    logic [QW-1:0]        q_rd;
    logic                 out_load;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = ssmh_reg_idx_t'(paddr[3:2]);
    assign mod_eff = (modulus_reg == '0) ? DATA_W'(1) : modulus_reg;
    assign full    = q_full;

    always_comb
    begin
        unique case (reg_idx)
            REG_MODULUS:  prdata = {1'b0, modulus_reg};
            REG_OFFSET:   prdata = {16'd0, offset_reg};
            REG_EXPONENT: prdata = {16'd0, exponent_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= RESET_MODULUS;
            offset_reg   <= RESET_OFFSET;
            exponent_reg <= RESET_EXPONENT;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_MODULUS:  modulus_reg  <= pwdata[DATA_W-1:0];
                REG_OFFSET:   offset_reg   <= pwdata[15:0];
                REG_EXPONENT: exponent_reg <= pwdata[15:0];
                default:      modulus_reg  <= modulus_reg;
            endcase
        end
    end

    ssmh_front #(.NUM_WIDTH(NUM_WIDTH)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .text_byte     (text_byte),
        .end_of_stream (end_of_stream),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_flags       (f_flags),
        .q_num         (f_num)
    );

    ssmh_fifo #(.WIDTH(QW), .DEPTH(CMD_DEPTH)) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data ({f_flags, f_num}),
        .rd_en   (q_pop),
        .rd_data (q_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign b_flags = ssmh_flags_t'(q_rd[QW-1:NUM_WIDTH]);
    assign b_num   = q_rd[NUM_WIDTH-1:0];

    ssmh_back #(.NUM_WIDTH(NUM_WIDTH), .AW(AW)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_flags  (b_flags),
        .q_num    (b_num),
        .q_pop    (q_pop),
        .mod_eff  (mod_eff),
        .offset   (offset_reg),
        .exponent (exponent_reg),
        .pop      (pop),
        .empty    (empty),
        .digest   (digest),
        .out_load (out_load)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("command popped from empty queue");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (empty || pop))
        else $error("digest overwritten before transfer");

    a_digest_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (digest < mod_eff))
        else $error("digest not reduced");

endmodule

/* sim/tb_top.sv */
// self-checking testbench for the set-of-sets modular exponentiation hash
`timescale 1ns / 1ps
module tb_top;
    import ssmh_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                push = 1'b0;
    logic                full;
    logic [7:0]          text_byte = '0;
    logic                end_of_stream = 1'b0;
    logic                pop = 1'b0;
    logic                empty;
    logic [DATA_W-1:0]   digest;

    longint unsigned     cur_mod, cur_off, cur_exp;
    longint unsigned     num_val, line_val, total_val;
    logic [DATA_W-1:0]   digest_q[$];
    bit                  quiet = 1'b0;
    int                  n_fail = 0;

    set_of_sets_modexp_hash u_dut (.*);

    always #5 clk = ~clk;

    function automatic longint unsigned wrap_mod();
        return (cur_mod == 0) ? 1 : cur_mod;
    endfunction

    function automatic longint unsigned power_hash(longint unsigned base);
        longint unsigned m, b, r, e;
        m = wrap_mod();
        b = (base + cur_off) % m;
        r = 1 % m;
        e = cur_exp;
        while (e != 0)
        begin
            if (e[0])
                r = (r * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic void close_number();
        if (num_val != 0)
            line_val = (line_val + power_hash(num_val)) % wrap_mod();
        num_val = 0;
    endfunction

    function automatic void close_line();
        close_number();
        if (line_val != 0)
            total_val = (total_val + power_hash(line_val)) % wrap_mod();
        line_val = 0;
    endfunction

    function automatic void predict_digest(logic [7:0] b, logic eos);
        if (eos)
        begin
            close_line();
            digest_q = {digest_q, DATA_W'(total_val % wrap_mod())};
            num_val = 0;
            line_val = 0;
            total_val = 0;
        end
        else if (b >= CHAR_ZERO && b <= CHAR_NINE)
            num_val = (num_val * 10 + (b - CHAR_ZERO)) & 64'h7FFF_FFFF;
        else if (b == CHAR_NEWLINE)
            close_line();
        else
            close_number();
    endfunction

    task automatic reg_write(ssmh_reg_idx_t idx, longint unsigned val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = PADDR_W'({idx, 2'b00});
        pwdata = 32'(val);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_MODULUS:  cur_mod = val & 64'h7FFF_FFFF;
            REG_OFFSET:   cur_off = val & 64'hFFFF;
            REG_EXPONENT: cur_exp = val & 64'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_regs(longint unsigned m, longint unsigned o, longint unsigned e);
        reg_write(REG_MODULUS, m);
        reg_write(REG_OFFSET, o);
        reg_write(REG_EXPONENT, e);
    endtask

    task automatic send_item(logic [7:0] b, logic eos);
        if (!quiet && $urandom_range(99) < 21)
            repeat ($urandom_range(4, 1)) @(negedge clk);
        push = 1'b1;
        text_byte = b;
        end_of_stream = eos;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        predict_digest(b, eos);
        @(negedge clk);
        push = 1'b0;
        text_byte = 8'($urandom_range(255));
        end_of_stream = 1'($urandom_range(1));
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send_item(s[i], 1'b0);
    endtask

    task automatic drain();
        wait (digest_q.size() == 0);
        repeat (200) @(posedge clk);
    endtask

    always @(negedge clk)
        pop <= quiet || ($urandom_range(99) >= 21);

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (digest_q.size() == 0)
            begin
                $error("digest transfer with none expected: actual %0d", digest);
                n_fail++;
            end
            else
            begin
                if (digest !== digest_q[0])
                begin
                    $error("digest mismatch: expected %0d actual %0d", digest_q[0], digest);
                    n_fail++;
                end
                void'(digest_q.pop_front());
            end
        end
    end

    task automatic test_defaults();
        send_text("12 34\n5\n");
        send_item(8'd0, 1'b1);
        send_text("0 000\n\n\n");
        send_item(8'hFF, 1'b1);
        send_text("98765432109876543210123456789\n");
        send_item(8'd7, 1'b1);
        send_item(8'd255, 1'b0);
        send_text("9");
        send_item(8'd128, 1'b0);
        send_item(8'd13, 1'b0);
        send_text("10");
        send_item(8'd0, 1'b1);
        send_item(8'd0, 1'b1);
        drain();
    endtask

    task automatic test_reg_extremes();
        set_regs(64'd2147483647, 64'd65535, 64'd65535);
        send_text("4294967295 1\n7\n");
        send_item(8'd0, 1'b1);
        drain();
        set_regs(64'd1, 64'd0, 64'd3);
        send_text("5 6\n");
        send_item(8'd0, 1'b1);
        drain();
        set_regs(64'd0, 64'd9, 64'd3);
        send_text("5 6\n");
        send_item(8'd0, 1'b1);
        drain();
        set_regs(64'd2, 64'd1, 64'd0);
        send_text("3 8\n1\n");
        send_item(8'd0, 1'b1);
        drain();
        set_regs(64'd1000003, 64'd0, 64'd1);
        send_text("3 8\n1 2\n");
        send_item(8'd0, 1'b1);
        drain();
    endtask

    task automatic test_random_text();
        int r;
        for (int ph = 0; ph < 11; ph++)
        begin
            quiet = (ph == 5);
            case ($urandom_range(3))
                0: cur_mod = $urandom_range(100, 2);
                1: cur_mod = 64'd2147483647;
                default: cur_mod = $urandom_range(32'h7FFF_FFFF, 2);
            endcase
            set_regs(cur_mod, $urandom_range(65535), ($urandom_range(9) == 0)
                     ? $urandom_range(65535) : $urandom_range(40));
            for (int k = 0; k < 100; k++)
            begin
                r = $urandom_range(99);
                if (r < 55)
                    send_item(8'(CHAR_ZERO + $urandom_range(9)), 1'b0);
                else if (r < 72)
                    send_item(8'd32, 1'b0);
                else if (r < 85)
                    send_item(CHAR_NEWLINE, 1'b0);
                else if (r < 95)
                    send_item(8'($urandom_range(255)), 1'b0);
                else
                    send_item(8'($urandom_range(255)), 1'b1);
            end
            send_item(8'($urandom_range(255)), 1'b1);
            drain();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        cur_mod = RESET_MODULUS;
        cur_off = RESET_OFFSET;
        cur_exp = RESET_EXPONENT;
        num_val = 0;
        line_val = 0;
        total_val = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_defaults();
        test_reg_extremes();
        test_random_text();
        if (n_fail == 0 && digest_q.size() == 0)
            $display("set_of_sets_modexp_hash test passed");
        else
            $display("set_of_sets_modexp_hash test failed");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("set_of_sets_modexp_hash test failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/ssmh_pkg.sv
rtl/ssmh_front.sv
rtl/ssmh_fifo.sv
rtl/ssmh_modmul.sv
rtl/ssmh_back.sv
rtl/set_of_sets_modexp_hash.sv
sim/tb_top.sv
